>>> rtl/skat_pkg.sv
package skat_pkg;

  localparam int unsigned KeyW    = 37;
  localparam int unsigned AmtW    = 32;
  localparam int unsigned DeltaW  = AmtW + 1;
  localparam int unsigned OpCntW  = 16;
  localparam int unsigned OutBalW = 48;
  localparam int unsigned TotalW  = 7;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 112;

  typedef enum logic [1:0] {
    CMD_WITHDRAW = 2'd0,
    CMD_DEPOSIT  = 2'd1,
    CMD_TRANSFER = 2'd2,
    CMD_POP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // operation applied to the cell row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_UPSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e                  op;
    logic [KeyW-1:0]           key;
    logic signed [DeltaW-1:0]  delta;
    logic                      ins_ok;  // key absent and room left
  } cell_ctrl_t;

endpackage

>>> rtl/skat_cell.sv
module skat_cell import skat_pkg::*; #(
  parameter int unsigned BAL_W = 48
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     occupied_i,
  input  logic                     left_lt_i,    // left neighbor key below op key
  input  logic [KeyW-1:0]          left_key_i,
  input  logic [BAL_W-1:0]         left_bal_i,
  input  logic [OpCntW-1:0]        left_cnt_i,
  input  logic [KeyW-1:0]          right_key_i,
  input  logic [BAL_W-1:0]         right_bal_i,
  input  logic [OpCntW-1:0]        right_cnt_i,
  output logic                     lt_o,
  output logic                     eq_o,
  output logic [KeyW-1:0]          key_o,
  output logic [BAL_W-1:0]         bal_o,
  output logic [OpCntW-1:0]        cnt_o
);

  localparam logic [BAL_W-1:0] BalMax = {1'b0, {(BAL_W-1){1'b1}}};
  localparam logic [BAL_W-1:0] BalMin = {1'b1, {(BAL_W-1){1'b0}}};

  logic [KeyW-1:0]   key_q, key_d;
  logic [BAL_W-1:0]  bal_q, bal_d;
  logic [OpCntW-1:0] cnt_q, cnt_d;

  logic signed [BAL_W:0] delta_ext;
  logic signed [BAL_W:0] sum;
  logic [BAL_W-1:0]      sat_bal;
  logic [BAL_W-1:0]      new_bal;

  assign lt_o = occupied_i && (key_q < ctrl_i.key);
  assign eq_o = occupied_i && (key_q == ctrl_i.key);

  assign delta_ext = (BAL_W+1)'(ctrl_i.delta);
  assign sum       = $signed({bal_q[BAL_W-1], bal_q}) + delta_ext;
  assign sat_bal   = (sum[BAL_W] != sum[BAL_W-1]) ? (sum[BAL_W] ? BalMin : BalMax)
                                                  : sum[BAL_W-1:0];
  assign new_bal   = BAL_W'(ctrl_i.delta);

  always_comb begin
    key_d = key_q;
    bal_d = bal_q;
    cnt_d = cnt_q;
    case (ctrl_i.op)
      CELL_UPSERT: begin
        if (eq_o) begin
          bal_d = sat_bal;
          if (cnt_q != '1) begin
            cnt_d = cnt_q + OpCntW'(1);
          end
        end else if (ctrl_i.ins_ok && !lt_o) begin
          if (left_lt_i) begin
            // insertion point
            key_d = ctrl_i.key;
            bal_d = new_bal;
            cnt_d = OpCntW'(1);
          end else begin
            key_d = left_key_i;
            bal_d = left_bal_i;
            cnt_d = left_cnt_i;
          end
        end
      end
      CELL_POP: begin
        key_d = right_key_i;
        bal_d = right_bal_i;
        cnt_d = right_cnt_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    bal_q <= bal_d;
    cnt_q <= cnt_d;
  end

  assign key_o = key_q;
  assign bal_o = bal_q;
  assign cnt_o = cnt_q;

endmodule

>>> rtl/sorted_key_accumulate_table.sv
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+--------------------------------------------
// s_axis   | in  | s_tvalid/s_tready   | cmd, amount, source_key, dest_key
// m_axis   | out | m_tvalid/m_tready   | status, popped_key, popped_balance,
//          |     |                     | popped_count, entry_total
//
// Withdraw and pop are one pass through the cell row, deposit and transfer two:
// every upsert is one pass, and the row shifts by at most one slot per cycle.
// The result lands in the output register at the end of the last pass.
// A new transfer is taken once the row is idle and the output register is free
// or draining in that cycle. Stalls on m_axis hold the result.
// Reset clears the fill count, the state and the output valid; cell contents
// stay undefined until written.
module sorted_key_accumulate_table import skat_pkg::*; #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned BALANCE_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  // [1:0] cmd, [33:2] amount, [70:34] source_key, [107:71] dest_key, rest zero
  input  logic [InDataW-1:0]   s_tdata_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  // [1:0] status, [38:2] popped_key, [86:39] popped_balance,
  // [102:87] popped_count, [109:103] entry_total, rest zero
  output logic [OutDataW-1:0]  m_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DEST = 2'b10
  } state_e;

  state_e state_q, state_d;

  // input fields
  cmd_e            in_cmd;
  logic [AmtW-1:0] in_amt;
  logic [KeyW-1:0] in_src;
  logic [KeyW-1:0] in_dst;

  assign in_cmd = cmd_e'(s_tdata_i[1:0]);
  assign in_amt = s_tdata_i[33:2];
  assign in_src = s_tdata_i[70:34];
  assign in_dst = s_tdata_i[107:71];

  // second-pass operands
  logic [AmtW-1:0] amt_q;
  logic [KeyW-1:0] dst_q;
  logic            drop_q, drop_d;

  logic [CntW-1:0] count_q, count_d;

  logic out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [KeyW-1:0]       out_key_q, out_key_d;
  logic [OutBalW-1:0]    out_bal_q, out_bal_d;
  logic [OpCntW-1:0]     out_cnt_q, out_cnt_d;
  logic [TotalW-1:0]     out_total_q, out_total_d;

  logic accept;
  logic write_out;
  cell_ctrl_t ctrl;

  // cell row wiring
  logic [KeyW-1:0]          cell_key [CAPACITY];
  logic [BALANCE_BITS-1:0]  cell_bal [CAPACITY];
  logic [OpCntW-1:0]        cell_cnt [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_eq;

  logic any_match;
  logic full;
  logic drop_now;
  logic empty;

  logic signed [DeltaW-1:0] amt_neg;
  logic signed [63:0]       head_bal_ext;

  assign s_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_tready_i);
  assign accept     = s_tvalid_i && s_tready_o;

  assign amt_neg = $signed(~{1'b0, in_amt} + DeltaW'(1));

  assign any_match = |cell_eq;
  assign full      = (count_q == CntFull);
  assign empty     = (count_q == '0);

  // broadcast control for this cycle
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.key    = in_src;
    ctrl.delta  = amt_neg;
    ctrl.ins_ok = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd) inside
            CMD_WITHDRAW, CMD_TRANSFER: ctrl.op = CELL_UPSERT;
            CMD_DEPOSIT: begin
              ctrl.op    = CELL_UPSERT;
              ctrl.delta = '0;
            end
            default: ctrl.op = CELL_POP;
          endcase
        end
      end
      ST_DEST: begin
        ctrl.op    = CELL_UPSERT;
        ctrl.key   = dst_q;
        ctrl.delta = $signed({1'b0, amt_q});
      end
      default: ;
    endcase
    ctrl.ins_ok = !any_match && !full;
  end

  assign drop_now = (ctrl.op == CELL_UPSERT) && !any_match && full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     occ;
    logic                     left_lt;
    logic [KeyW-1:0]          left_key;
    logic [BALANCE_BITS-1:0]  left_bal;
    logic [OpCntW-1:0]        left_cnt;
    logic [KeyW-1:0]          right_key;
    logic [BALANCE_BITS-1:0]  right_bal;
    logic [OpCntW-1:0]        right_cnt;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = '0;
      assign left_bal = '0;
      assign left_cnt = '0;
    end else begin : g_inner_l
      assign left_lt  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
      assign left_bal = cell_bal[i-1];
      assign left_cnt = cell_cnt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = '0;
      assign right_bal = '0;
      assign right_cnt = '0;
    end else begin : g_inner_r
      assign right_key = cell_key[i+1];
      assign right_bal = cell_bal[i+1];
      assign right_cnt = cell_cnt[i+1];
    end

    skat_cell #(
      .BAL_W (BALANCE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occ),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .left_bal_i  (left_bal),
      .left_cnt_i  (left_cnt),
      .right_key_i (right_key),
      .right_bal_i (right_bal),
      .right_cnt_i (right_cnt),
      .lt_o        (cell_lt[i]),
      .eq_o        (cell_eq[i]),
      .key_o       (cell_key[i]),
      .bal_o       (cell_bal[i]),
      .cnt_o       (cell_cnt[i])
    );
  end

  // head balance sign-extended, then cut to the output width
  assign head_bal_ext = 64'($signed(cell_bal[0]));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    drop_d       = drop_q;
    write_out    = 1'b0;
    out_status_d = STATUS_OK;
    out_key_d    = '0;
    out_bal_d    = '0;
    out_cnt_d    = '0;

    if (ctrl.op == CELL_UPSERT && ctrl.ins_ok) begin
      count_d = count_q + CntW'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          drop_d = drop_now;
          case (in_cmd)
            CMD_WITHDRAW: begin
              write_out = 1'b1;
              if (drop_now) begin
                out_status_d = STATUS_FULL;
              end
            end
            CMD_POP: begin
              write_out = 1'b1;
              if (empty) begin
                out_status_d = STATUS_EMPTY;
              end else begin
                count_d   = count_q - CntW'(1);
                out_key_d = cell_key[0];
                out_bal_d = head_bal_ext[OutBalW-1:0];
                out_cnt_d = cell_cnt[0];
              end
            end
            default: state_d = ST_DEST;
          endcase
        end
      end
      ST_DEST: begin
        write_out = 1'b1;
        state_d   = ST_IDLE;
        if (drop_now || drop_q) begin
          out_status_d = STATUS_FULL;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_total_d = TotalW'(count_d);

    if (write_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q <= drop_d;
    if (accept) begin
      amt_q <= in_amt;
      dst_q <= in_dst;
    end
    if (write_out) begin
      out_status_q <= out_status_d;
      out_key_q    <= out_key_d;
      out_bal_q    <= out_bal_d;
      out_cnt_q    <= out_cnt_d;
      out_total_q  <= out_total_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_total_q, out_cnt_q, out_bal_q, out_key_q, out_status_q};

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import skat_pkg::*;

  localparam int unsigned Depth    = 64;
  localparam int unsigned BalW     = 48;
  localparam longint      BalMax   = (longint'(1) << (BalW - 1)) - 1;
  localparam longint      BalMin   = -BalMax - 1;
  localparam int unsigned CountMax = 65535;
  localparam int unsigned PoolSize = 80;

  localparam logic [KeyW-1:0] KeyTop     = '1;
  localparam logic [KeyW-1:0] DecimalTop = 37'd99999999999;

  typedef struct {
    status_e            status;
    logic [KeyW-1:0]    key;
    logic [OutBalW-1:0] bal;
    logic [OpCntW-1:0]  cnt;
    logic [TotalW-1:0]  total;
  } outcome_t;

  // Mirror of the sorted table plus the queue of outcomes still owed.
  class ledger_tracker;
    logic [KeyW-1:0] keys [Depth];
    longint          balances [Depth];
    int unsigned     op_counts [Depth];
    int unsigned     fill;
    outcome_t        awaited [$];
    int unsigned     mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function longint bounded_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > BalMax) return BalMax;
      if (s < BalMin) return BalMin;
      return s;
    endfunction

    // 1 when a new key could not be placed because the table is full
    function bit apply_upsert(logic [KeyW-1:0] key, longint delta);
      int unsigned pos;
      int unsigned j;
      pos = 0;
      while (pos < fill && keys[pos] < key) pos++;
      if (pos < fill && keys[pos] == key) begin
        balances[pos] = bounded_sum(balances[pos], delta);
        if (op_counts[pos] < CountMax) op_counts[pos]++;
        return 1'b0;
      end
      if (fill >= Depth) return 1'b1;
      for (j = fill; j > pos; j--) begin
        keys[j]      = keys[j-1];
        balances[j]  = balances[j-1];
        op_counts[j] = op_counts[j-1];
      end
      keys[pos]      = key;
      balances[pos]  = bounded_sum(0, delta);
      op_counts[pos] = 1;
      fill++;
      return 1'b0;
    endfunction

    function void note_command(cmd_e cmd, logic [AmtW-1:0] amount,
                               logic [KeyW-1:0] src, logic [KeyW-1:0] dst);
      outcome_t    want;
      bit          dropped;
      longint      amt;
      longint      b;
      int unsigned j;
      amt         = longint'({32'b0, amount});
      dropped     = 1'b0;
      want.status = STATUS_OK;
      want.key    = '0;
      want.bal    = '0;
      want.cnt    = '0;
      case (cmd)
        CMD_WITHDRAW: begin
          dropped = apply_upsert(src, -amt);
        end
        CMD_DEPOSIT: begin
          dropped = apply_upsert(src, 0);
          if (apply_upsert(dst, amt)) dropped = 1'b1;
        end
        CMD_TRANSFER: begin
          dropped = apply_upsert(src, -amt);
          if (apply_upsert(dst, amt)) dropped = 1'b1;
        end
        default: begin
          if (fill == 0) begin
            want.status = STATUS_EMPTY;
          end else begin
            b        = balances[0];
            want.key = keys[0];
            want.bal = b[OutBalW-1:0];
            want.cnt = op_counts[0][OpCntW-1:0];
            for (j = 1; j < fill; j++) begin
              keys[j-1]      = keys[j];
              balances[j-1]  = balances[j];
              op_counts[j-1] = op_counts[j];
            end
            fill--;
          end
        end
      endcase
      if (dropped) want.status = STATUS_FULL;
      want.total = fill[TotalW-1:0];
      awaited.push_back(want);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      if (want === got) return;
      mismatches++;
      if (mismatches <= 10)
        $display("tb: %s mismatch, expected %h, got %h", what, want, got);
    endfunction

    function void check_outcome(logic [OutDataW-1:0] data);
      outcome_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result %h arrived with nothing pending", data);
        return;
      end
      want = awaited.pop_front();
      flag("status", 64'(want.status), 64'(data[1:0]));
      flag("popped_key", 64'(want.key), 64'(data[38:2]));
      flag("popped_balance", 64'(want.bal), 64'(data[86:39]));
      flag("popped_count", 64'(want.cnt), 64'(data[102:87]));
      flag("entry_total", 64'(want.total), 64'(data[109:103]));
    endfunction
  endclass

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i  = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;

  ledger_tracker   ledger = new();
  bit              calm   = 1'b0;  // no idling on either side while set
  logic [KeyW-1:0] key_pool [PoolSize];

  sorted_key_accumulate_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly none or short, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [KeyW-1:0] any_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    return k[KeyW-1:0];
  endfunction

  // a small pool keeps hits frequent and lets the table fill up
  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, PoolSize - 1)];
    return any_key();
  endfunction

  function automatic logic [AmtW-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return AmtW'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  // Leaves tvalid high after the transfer so back-to-back items need no toggle.
  task automatic push_command(cmd_e cmd, logic [AmtW-1:0] amount,
                              logic [KeyW-1:0] src, logic [KeyW-1:0] dst);
    int unsigned gap;
    gap = idle_span();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {4'b0, dst, src, amount, cmd};
    forever begin
      @(posedge clk_i);
      if (s_tvalid_i && s_tready_o) break;
    end
    ledger.note_command(cmd, amount, src, dst);
    @(negedge clk_i);
  endtask

  task automatic random_block(int unsigned items, int unsigned pop_pct);
    logic [KeyW-1:0] src;
    cmd_e            cmd;
    repeat (items) begin
      if ($urandom_range(0, 99) < pop_pct) cmd = CMD_POP;
      else cmd = cmd_e'($urandom_range(0, 2));
      src = pick_key();
      push_command(cmd, pick_amount(), src,
                   ($urandom_range(0, 9) == 0) ? src : pick_key());
    end
  endtask

  task automatic drain_table();
    repeat (Depth + 6) push_command(CMD_POP, $urandom, any_key(), any_key());
  endtask

  // receiver side: random back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_tready_i <= 1'b1;
        stall_left = idle_span();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) ledger.check_outcome(m_tdata_o);
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned pop_mix [8];
    int unsigned i;
    pop_mix = '{2, 25, 50, 10, 70, 3, 35, 60};
    key_pool[0] = '0;
    key_pool[1] = KeyTop;
    key_pool[2] = DecimalTop;
    for (i = 3; i < PoolSize; i++) key_pool[i] = any_key();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty pop, field extremes, every command, same source and dest
    push_command(CMD_POP, '1, KeyTop, KeyTop);
    push_command(CMD_WITHDRAW, '0, '0, '0);
    push_command(CMD_WITHDRAW, '1, KeyTop, '0);
    push_command(CMD_DEPOSIT, '1, DecimalTop, '0);
    push_command(CMD_TRANSFER, 32'd1234, 37'd5, 37'd5);
    push_command(CMD_DEPOSIT, 32'd1, 37'd7, 37'd7);
    push_command(CMD_TRANSFER, 32'h8000_0000, 37'd6, KeyTop);
    push_command(CMD_WITHDRAW, 32'h8000_0000, '0, KeyTop);
    push_command(CMD_DEPOSIT, 32'h7FFF_FFFF, 37'h15_5555_5555, 37'h0A_AAAA_AAAA);
    push_command(CMD_TRANSFER, '1, 37'h0A_AAAA_AAAA, DecimalTop);
    push_command(CMD_WITHDRAW, '1, KeyTop, '0);
    push_command(CMD_POP, '0, '0, '0);
    push_command(CMD_POP, '0, '0, '0);
    push_command(CMD_TRANSFER, 32'd99, 37'd7, 37'd8);
    repeat (10) push_command(CMD_POP, $urandom, any_key(), any_key());

    // random: pop rate per block swings the fill between empty and full
    for (i = 0; i < 8; i++) begin
      calm = (i % 4 == 3);
      random_block(170, pop_mix[i]);
    end

    // repeated hits: one key driven up, another driven down
    calm = 1'b1;
    drain_table();
    repeat (40) push_command(CMD_DEPOSIT, '1, 37'h12_3456_789A, 37'h12_3456_789A);
    repeat (40) push_command(CMD_WITHDRAW, '1, 37'h01_0000_0001, '0);
    calm = 1'b0;
    drain_table();
    s_tvalid_i <= 1'b0;

    while (ledger.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (ledger.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/skat_pkg.sv
rtl/skat_cell.sv
rtl/sorted_key_accumulate_table.sv
bench/tb.sv
